### rtl/cq_pkg.sv
// Shared types and constants for the circular queue with peek and poke.
`timescale 1ns / 1ps

package cq_pkg;

  localparam int DepthDefault     = 16;
  localparam int DataWidthDefault = 32;

  localparam int IdxW  = 12;  // slot_index field
  localparam int WordW = 32;  // data_in and data_out fields
  localparam int CfgW  = 5;   // depth_in_use register
  localparam int RemW  = CfgW;

  typedef enum logic [1:0] {
    MODE_PUT  = 2'd0,
    MODE_GET  = 2'd1,
    MODE_PEEK = 2'd2,
    MODE_POKE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_EDGE   = 2'd1,
    STAT_REJECT = 2'd2,
    STAT_RANGE  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FILL_EMPTY   = 2'd0,
    FILL_PARTIAL = 2'd1,
    FILL_FULL    = 2'd2
  } fill_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_MOD,
    S_PEEK_RD,
    S_RD_WAIT,
    S_RESP
  } state_e;

  typedef struct packed {
    mode_e             mode;
    logic [IdxW-1:0]   slot_index;
    logic [WordW-1:0]  data_in;
    logic              burst_end;
  } in_word_t;

  typedef struct packed {
    logic [WordW-1:0]  data_out;
    status_e           status;
    fill_e             fill_state;
    logic              call_done;
  } out_word_t;

endpackage

### rtl/cq_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module cq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/cq_cmpsub.sv
// Shared compare-and-subtract unit: reports a >= b and gives a - b.
`timescale 1ns / 1ps

module cq_cmpsub #(
  parameter int W = 12
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  output logic         ge_o,
  output logic [W-1:0] diff_o
);

  logic borrow;

  assign {borrow, diff_o} = {1'b0, a_i} - {1'b0, b_i};
  assign ge_o = ~borrow;

endmodule

### rtl/circular_queue_with_peek_poke_core.sv
// Circular queue of data words with put, get, peek and poke, run by a small sequencer.
// From accept to result strobe: put, poke and rejected get pass the execute state, get adds a
// read wait, and peek runs 12 restoring modulo steps, one read issue, one read wait, one result.
// busy is high from accept until the result cycle ends, so no new item is taken before then.
// After reset the slot store is swept to zero, one slot per cycle, with busy high;
// configuration writes are taken during that sweep. The receiver cannot stall results.
`timescale 1ns / 1ps

module circular_queue_with_peek_poke_core
  import cq_pkg::*;
#(
  parameter int DEPTH      = DepthDefault,
  parameter int DATA_WIDTH = DataWidthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  in_word_t        in_i,
  output logic            res_valid_o,
  output out_word_t       res_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [CfgW-1:0] cfg_data_i
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CntW = $clog2(IdxW);

  // Depth in use after reset is 16, or DEPTH when the store is smaller.
  localparam logic [CfgW-1:0] DepthReset = (DEPTH < 16) ? CfgW'(DEPTH) : CfgW'(16);

  state_e             state_q, state_d;
  in_word_t           item_q, item_d;
  logic [AW-1:0]      head_q, head_d;
  logic [AW-1:0]      tail_q, tail_d;
  fill_e              fill_q, fill_d;
  logic [CfgW-1:0]    depth_q, depth_d;
  logic [RemW-1:0]    rem_q, rem_d;
  logic [IdxW-1:0]    shreg_q, shreg_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [AW-1:0]      clr_q, clr_d;
  logic [WordW-1:0]   dout_q, dout_d;
  status_e            status_q, status_d;

  // Shared unit and memory port.
  logic [IdxW-1:0]       alu_a, alu_b, alu_diff;
  logic                  alu_ge;
  logic                  mem_we;
  logic [AW-1:0]         mem_addr;
  logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;

  logic [AW-1:0]   next_ptr;
  logic [RemW:0]   mod_shift;
  logic [CfgW-1:0] cfg_clamped;

  cq_cmpsub #(.W(IdxW)) u_cmpsub (
    .a_i    (alu_a),
    .b_i    (alu_b),
    .ge_o   (alu_ge),
    .diff_o (alu_diff)
  );

  cq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // A written depth of zero means one slot; anything above the store size is clamped to it.
  always_comb begin
    if (cfg_data_i == '0) begin
      cfg_clamped = CfgW'(1);
    end else if (int'(cfg_data_i) > DEPTH) begin
      cfg_clamped = CfgW'(DEPTH);
    end else begin
      cfg_clamped = cfg_data_i;
    end
  end

  // When the shared unit is fed pointer + 1 against the depth, a "greater or equal" answer
  // means the pointer wraps to slot zero.
  assign next_ptr  = alu_ge ? '0 : AW'(alu_a);
  // One restoring step of the peek modulo: bring in the next index bit from the top.
  assign mod_shift = {rem_q, shreg_q[IdxW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      head_q  <= '0;
      tail_q  <= '0;
      fill_q  <= FILL_EMPTY;
      depth_q <= DepthReset;
      clr_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      fill_q  <= fill_d;
      depth_q <= depth_d;
      clr_q   <= clr_d;
      cnt_q   <= cnt_d;
    end
  end

  // Item and result payload carry no reset.
  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    rem_q    <= rem_d;
    shreg_q  <= shreg_d;
    dout_q   <= dout_d;
    status_q <= status_d;
  end

  always_comb begin
    state_d   = state_q;
    item_d    = item_q;
    head_d    = head_q;
    tail_d    = tail_q;
    fill_d    = fill_q;
    depth_d   = depth_q;
    rem_d     = rem_q;
    shreg_d   = shreg_q;
    cnt_d     = cnt_q;
    clr_d     = clr_q;
    dout_d    = dout_q;
    status_d  = status_q;

    alu_a     = '0;
    alu_b     = IdxW'(depth_q);
    mem_we    = 1'b0;
    mem_addr  = '0;
    mem_wdata = DATA_WIDTH'(item_q.data_in);

    unique case (state_q)
      S_CLEAR: begin
        // Zero the whole store so that a peek of a never-written slot reads zero.
        mem_we    = 1'b1;
        mem_addr  = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          item_d   = in_i;
          shreg_d  = in_i.slot_index;
          rem_d    = '0;
          cnt_d    = '0;
          dout_d   = '0;
          status_d = STAT_OK;
          state_d  = (in_i.mode == MODE_PEEK) ? S_MOD : S_EXEC;
        end
      end

      S_EXEC: begin
        state_d = S_RESP;
        unique case (item_q.mode)
          MODE_PUT: begin
            if (fill_q == FILL_FULL) begin
              status_d = STAT_REJECT;
            end else begin
              mem_we   = 1'b1;
              mem_addr = tail_q;
              alu_a    = IdxW'(tail_q) + IdxW'(1);
              tail_d   = next_ptr;
              if (next_ptr == head_q) begin
                fill_d   = FILL_FULL;
                status_d = STAT_EDGE;
              end else begin
                fill_d   = FILL_PARTIAL;
                status_d = STAT_OK;
              end
            end
          end
          MODE_GET: begin
            if (fill_q == FILL_EMPTY) begin
              status_d = STAT_REJECT;
            end else begin
              // The head slot is read here; its word arrives in the wait state.
              mem_addr = head_q;
              alu_a    = IdxW'(head_q) + IdxW'(1);
              head_d   = next_ptr;
              if (next_ptr == tail_q) begin
                fill_d   = FILL_EMPTY;
                status_d = STAT_EDGE;
              end else begin
                fill_d   = FILL_PARTIAL;
                status_d = STAT_OK;
              end
              state_d = S_RD_WAIT;
            end
          end
          MODE_POKE: begin
            alu_a = item_q.slot_index;
            if (alu_ge) begin
              status_d = STAT_RANGE;
            end else begin
              mem_we   = 1'b1;
              mem_addr = AW'(item_q.slot_index);
            end
          end
          MODE_PEEK: begin
            // Peek runs through the modulo states and never lands here.
            state_d = S_RESP;
          end
        endcase
      end

      S_MOD: begin
        alu_a   = IdxW'(mod_shift);
        rem_d   = alu_ge ? RemW'(alu_diff) : RemW'(mod_shift);
        shreg_d = shreg_q << 1;
        cnt_d   = cnt_q + CntW'(1);
        if (cnt_q == CntW'(IdxW - 1)) begin
          state_d = S_PEEK_RD;
        end
      end

      S_PEEK_RD: begin
        mem_addr = AW'(rem_q);
        state_d  = S_RD_WAIT;
      end

      S_RD_WAIT: begin
        dout_d  = WordW'(mem_rdata);
        state_d = S_RESP;
      end

      S_RESP: begin
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // A depth write empties the queue; the slot contents stay.
    if (cfg_valid_i) begin
      depth_d = cfg_clamped;
      head_d  = '0;
      tail_d  = '0;
      fill_d  = FILL_EMPTY;
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign res_valid_o = (state_q == S_RESP);

  always_comb begin
    res_o.data_out   = dout_q;
    res_o.status     = status_q;
    res_o.fill_state = fill_q;
    res_o.call_done  = item_q.burst_end;
  end

endmodule

### bench/tb_top.sv
// Self-checking testbench for the circular queue core: directed corners, then random put/get/peek/poke bursts.
`timescale 1ns / 1ps

module tb_top;
  import cq_pkg::*;

  // Tracks the queue as the block should see it. Every accepted word is run through the same
  // put/get/peek/poke rules to produce the one reply it must cause, and the replies are then
  // matched in order against what the block strobes out.
  class cq_tracker;
    logic [WordW-1:0] slots [DepthDefault];
    int unsigned      head;
    int unsigned      tail;
    int unsigned      depth;
    fill_e            fill;
    out_word_t        replies_due[$];
    int unsigned      errors;
    int unsigned      mode_count[4];
    int unsigned      edge_count, reject_count, range_count, depth_writes;

    function new();
      foreach (slots[i]) slots[i] = '0;
      head  = 0;
      tail  = 0;
      depth = DepthDefault;
      fill  = FILL_EMPTY;
    endfunction

    // A depth write clamps into 1..DEPTH and empties the queue; slot contents survive.
    function void set_depth(logic [CfgW-1:0] v);
      depth = (v == 0) ? 1 : ((v > DepthDefault) ? DepthDefault : v);
      head  = 0;
      tail  = 0;
      fill  = FILL_EMPTY;
      depth_writes++;
    endfunction

    function int unsigned step_ptr(int unsigned p);
      return (p + 1 >= depth) ? 0 : p + 1;
    endfunction

    function void take_word(in_word_t w);
      out_word_t r;
      r = '0;
      r.status = STAT_OK;
      case (w.mode)
        MODE_PUT: begin
          if (fill == FILL_FULL) begin
            r.status = STAT_REJECT;
          end else begin
            slots[tail] = w.data_in;
            tail = step_ptr(tail);
            fill = (tail == head) ? FILL_FULL : FILL_PARTIAL;
            if (fill == FILL_FULL) r.status = STAT_EDGE;
          end
        end
        MODE_GET: begin
          if (fill == FILL_EMPTY) begin
            r.status = STAT_REJECT;
          end else begin
            r.data_out = slots[head];
            head = step_ptr(head);
            fill = (tail == head) ? FILL_EMPTY : FILL_PARTIAL;
            if (fill == FILL_EMPTY) r.status = STAT_EDGE;
          end
        end
        MODE_PEEK: r.data_out = slots[w.slot_index % depth];
        default: begin
          if (w.slot_index >= depth) r.status = STAT_RANGE;
          else slots[w.slot_index] = w.data_in;
        end
      endcase
      r.fill_state = fill;
      r.call_done  = w.burst_end;
      mode_count[w.mode]++;
      if (r.status == STAT_EDGE) edge_count++;
      if (r.status == STAT_REJECT) reject_count++;
      if (r.status == STAT_RANGE) range_count++;
      replies_due.push_back(r);
    endfunction

    function void compare_field(string name, logic [WordW-1:0] want, logic [WordW-1:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %h, got %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_reply(out_word_t got);
      out_word_t want;
      if (replies_due.size() == 0) begin
        $display("%0t: reply expected none, got data %h status %0d fill %0d done %0b",
                 $time, got.data_out, got.status, got.fill_state, got.call_done);
        errors++;
        return;
      end
      want = replies_due.pop_front();
      compare_field("data_out", want.data_out, got.data_out);
      compare_field("status", want.status, got.status);
      compare_field("fill_state", want.fill_state, got.fill_state);
      compare_field("call_done", want.call_done, got.call_done);
    endfunction
  endclass

  // Clock, reset and the block's ports. Every input starts at a known value.
  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            start;
  logic            busy;
  in_word_t        in_i;
  logic            res_valid_o;
  out_word_t       res_o;
  logic            cfg_valid_i;
  logic            cfg_ready_o;
  logic [CfgW-1:0] cfg_data_i;

  cq_tracker tracker = new();

  always #5 clk_i = ~clk_i;

  circular_queue_with_peek_poke_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_i        (in_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // Replies cannot be held off, so every strobed cycle is checked at the edge that ends it.
  // Reading the outputs right after the edge gives their values from before it.
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) tracker.check_reply(res_o);
  end

  // Mostly back-to-back, sometimes a few cycles, rarely a long pause. The long ones outlast
  // even a peek, so the next start lands on every phase of the sequencer, idle included.
  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 16);
    return $urandom_range(20, 40);
  endfunction

  // Slot numbers cluster inside the depth in use, just past it, and anywhere in 12 bits.
  function automatic logic [IdxW-1:0] pick_index();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return IdxW'($urandom_range(0, tracker.depth - 1));
    if (r < 70) return IdxW'(tracker.depth + $urandom_range(0, 3));
    if (r < 92) return IdxW'($urandom_range(0, (1 << IdxW) - 1));
    return (r < 96) ? '1 : '0;
  endfunction

  function automatic logic [WordW-1:0] pick_data();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return '1;
    return $urandom;
  endfunction

  // Presents one word and holds start until it is taken (start high, busy low at an edge).
  // With no gap start simply stays high for the next word, so it is never dropped and
  // raised in the same step.
  task automatic send(input mode_e m, input logic [IdxW-1:0] idx, input logic [WordW-1:0] d,
                      input logic last, input int unsigned gap);
    in_word_t w;
    w.mode       = m;
    w.slot_index = idx;
    w.data_in    = d;
    w.burst_end  = last;
    start <= 1'b1;
    in_i  <= w;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    tracker.take_word(w);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Every word yields exactly one reply, so an empty list of due replies means the block is
  // idle and the depth register may be rewritten.
  task automatic write_depth(input logic [CfgW-1:0] v);
    start <= 1'b0;
    while (tracker.replies_due.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    tracker.set_depth(v);
    cfg_valid_i <= 1'b0;
  endtask

  // Random traffic as the host would send it: calls of one to four elements of one kind,
  // the slot number stepped per element and the last one flagged. The put/get mix swings
  // between filling and draining so full and empty are both reached often. About one call
  // in ten has a scrambled end flag.
  task automatic run_phase(input int unsigned n, input bit calm);
    int unsigned sent, len, k, r, put_share;
    logic [IdxW-1:0] base;
    bit put_heavy, scrambled;
    mode_e m;
    sent      = 0;
    put_heavy = $urandom_range(0, 1);
    while (sent < n) begin
      if ($urandom_range(0, 19) == 0) put_heavy = !put_heavy;
      put_share = put_heavy ? 55 : 20;
      r = $urandom_range(0, 99);
      if (r < put_share) m = MODE_PUT;
      else if (r < 75) m = MODE_GET;
      else if (r < 88) m = MODE_PEEK;
      else m = MODE_POKE;
      len       = $urandom_range(1, 4);
      base      = pick_index();
      scrambled = ($urandom_range(0, 9) == 0);
      for (k = 0; k < len; k++) begin
        send(m, base + k[IdxW-1:0], pick_data(),
             scrambled ? 1'($urandom_range(0, 1)) : (k == len - 1), pick_gap(calm));
      end
      sent += len;
    end
  endtask

  initial begin
    int depth_plan[12];
    int unsigned spin;
    depth_plan = '{31, 1, 2, 16, 3, 0, 7, 17, 4, 15, 9, 5};
    // One phase gets a depth drawn from the whole 5-bit register range.
    depth_plan[$urandom_range(0, 11)] = $urandom_range(0, 31);

    rst_ni      <= 1'b0;
    start       <= 1'b0;
    in_i        <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed corners at the reset depth of 16. The store is swept to zero after reset, so
    // an early peek must read zero; peek wraps its index, poke refuses one past the depth.
    send(MODE_GET, '0, '1, 1'b1, pick_gap(0));            // get on empty is refused
    send(MODE_PEEK, '0, '0, 1'b0, pick_gap(0));
    send(MODE_PEEK, '1, '0, 1'b1, pick_gap(0));           // 4095 wraps to slot 15
    send(MODE_POKE, 12'd15, '1, 1'b1, pick_gap(0));
    send(MODE_POKE, 12'd16, '1, 1'b0, pick_gap(0));       // just past the depth
    send(MODE_POKE, '1, '1, 1'b1, pick_gap(0));
    send(MODE_PEEK, 12'd31, '0, 1'b0, pick_gap(0));       // sees the poke to slot 15
    send(MODE_PUT, '1, '0, 1'b0, pick_gap(0));
    send(MODE_PUT, '0, '1, 1'b1, pick_gap(0));
    send(MODE_GET, '0, '0, 1'b0, pick_gap(0));
    send(MODE_GET, '0, '0, 1'b1, pick_gap(0));            // drains to empty

    // A depth of zero is taken as one slot: one put fills it, a second is refused.
    write_depth(5'd0);
    send(MODE_PUT, '0, 32'hA5A5_A5A5, 1'b1, pick_gap(0));
    send(MODE_PUT, '0, 32'h0F0F_0F0F, 1'b1, pick_gap(0));
    send(MODE_PEEK, '1, '0, 1'b1, pick_gap(0));
    send(MODE_POKE, 12'd1, '1, 1'b1, pick_gap(0));
    send(MODE_POKE, 12'd0, 32'h5A5A_5A5A, 1'b1, pick_gap(0));
    send(MODE_GET, '0, '0, 1'b1, pick_gap(0));
    send(MODE_GET, '0, '0, 1'b1, pick_gap(0));

    // Two slots: the tail wraps back to slot 0 while the head sits at 1.
    write_depth(5'd2);
    send(MODE_PUT, '0, 32'h1111_1111, 1'b0, pick_gap(0));
    send(MODE_PUT, '0, 32'h2222_2222, 1'b1, pick_gap(0));
    send(MODE_GET, '0, '0, 1'b1, pick_gap(0));
    send(MODE_PUT, '0, 32'h3333_3333, 1'b1, pick_gap(0));
    send(MODE_GET, '0, '0, 1'b0, pick_gap(0));
    send(MODE_GET, '0, '0, 1'b1, pick_gap(0));

    // Random phases, each at its own depth; every fourth one runs without any gaps.
    foreach (depth_plan[i]) begin
      write_depth(depth_plan[i][CfgW-1:0]);
      run_phase(128, (i % 4) == 3);
    end

    // Let the last replies come in, then give the slowest item (a peek) time to show any
    // stray strobe.
    start <= 1'b0;
    spin = 0;
    while (tracker.replies_due.size() != 0 && spin < 1000) begin
      @(posedge clk_i);
      spin++;
    end
    repeat (20) @(posedge clk_i);
    if (tracker.replies_due.size() != 0) begin
      $display("%0t: %0d replies expected, none arrived", $time, tracker.replies_due.size());
      tracker.errors += tracker.replies_due.size();
    end

    $display("Covered %0d puts, %0d gets, %0d peeks, %0d pokes over %0d depth writes.",
             tracker.mode_count[MODE_PUT], tracker.mode_count[MODE_GET],
             tracker.mode_count[MODE_PEEK], tracker.mode_count[MODE_POKE],
             tracker.depth_writes);
    $display("Saw %0d full/empty transitions, %0d refused puts/gets, %0d out-of-range pokes.",
             tracker.edge_count, tracker.reject_count, tracker.range_count);
    if (tracker.errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // Watchdog: the slowest legal run is well under a tenth of this.
  initial begin
    #20_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

### filelist.f
rtl/cq_pkg.sv
rtl/cq_ram.sv
rtl/cq_cmpsub.sv
rtl/circular_queue_with_peek_poke_core.sv
bench/tb_top.sv
